/* design/brse_pkg.sv */
// Shared types and constants for the blocked sparse row encoder.
package brse_pkg;

  localparam int MAX_ROWS = 4096;
  localparam int MAX_COLS = 4096;

  localparam int CFG_W  = 13;
  localparam int CNT_W  = 12;
  localparam int POS_W  = 25;
  localparam int ELEM_W = 32;

  localparam logic [CFG_W-1:0] MAX_ROWS_C = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] MAX_COLS_C = CFG_W'(MAX_COLS);

  // Result kinds carried on tuser
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_POINTER = 1'b1;

  typedef enum logic [1:0] {
    REG_ROWS_IN_USE = 2'd0,
    REG_COLS_IN_USE = 2'd1,
    REG_BLOCK_WIDTH = 2'd2
  } cfg_reg_t;

  // Which of the up to three results an element causes
  typedef struct packed {
    logic has_end;
    logic has_payload;
    logic has_start;
  } result_mask_t;

  // Everything needed to replay the results of one element
  typedef struct packed {
    result_mask_t             mask;
    logic [ELEM_W-1:0]        value_bits;
    logic [CNT_W-1:0]         block_offset;
    logic [POS_W-1:0]         start_pos;
    logic [POS_W-1:0]         start_slot;
    logic [POS_W-1:0]         end_pos;
    logic [POS_W-1:0]         end_slot;
    logic                     end_of_matrix;
  } bundle_t;

endpackage

/* design/blocked_sparse_row_encoder.sv */
// Top level of the blocked sparse row encoder: dense float stream in, blocked CSR beats out.
// Latency: first result beat is valid the cycle after its element is accepted.
// Throughput: one element per cycle while each element causes at most one result and
//   out_tready stays high; an element causing more results (up to three) holds the result
//   register until all are sent, so the single result port draining it sets input rate.
// Reset: synchronous active-low; counters clear, config returns to 4096/4096/64.
module blocked_sparse_row_encoder
  import brse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // element stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] element_bits
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] value_bits, [43:32] block_offset,
                                  // [68:44] position, [93:69] pointer_slot,
                                  // [94] end_of_matrix, [95] zero pad
  output logic        out_tuser,  // [0] kind: 0 payload, 1 row-block pointer
  output logic        out_tlast   // last result beat of the element
);

  bundle_t bundle;
  logic    in_beat;
  logic    can_load;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  // a new element enters when the result register is empty or sends
  // its final beat this cycle
  assign in_tready = can_load;
  assign in_beat   = in_tvalid && in_tready;

  // counters and per-element decode (row start, payload, block end)
  brse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .elem_beat (in_beat),
    .elem_bits (in_tdata),
    .bundle    (bundle)
  );

  // result register, one beat per ready cycle in row-start, payload, block-end order
  brse_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_beat),
    .bundle_in (bundle),
    .can_load  (can_load),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_kind  (out_tuser),
    .res_data  (out_tdata),
    .res_last  (out_tlast)
  );

endmodule

/* design/brse_core.sv */
// Config registers, position counters and per-element result decode.
module brse_core
  import brse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  elem_beat,
  input  logic [ELEM_W-1:0]     elem_bits,
  output bundle_t               bundle
);

  logic [CFG_W-1:0] rows_r, cols_r, bw_r;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] off_r, off_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] nz_r, nz_nxt;
  logic [POS_W-1:0] slot_r, slot_nxt;

  logic [CFG_W-1:0] rows_c, cols_c, bw_c;
  logic             nonzero, first_col, row_end, blk_end, mat_end;
  logic [POS_W-1:0] slot_mid, end_pos;

  // zero acts as one, oversize saturates
  function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(4096);
      cols_r <= CFG_W'(4096);
      bw_r   <= CFG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_ROWS_IN_USE: rows_r <= cfg_wdata;
        REG_COLS_IN_USE: cols_r <= cfg_wdata;
        REG_BLOCK_WIDTH: bw_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_c    = clamp_reg(rows_r, MAX_ROWS_C);
    cols_c    = clamp_reg(cols_r, MAX_COLS_C);
    bw_c      = clamp_reg(bw_r, MAX_COLS_C);
    nonzero   = elem_bits[ELEM_W-2:0] != '0;
    first_col = col_r == '0;
    row_end   = {1'b0, col_r} >= (cols_c - CFG_W'(1));
    blk_end   = row_end || ({1'b0, off_r} >= (bw_c - CFG_W'(1)));
    mat_end   = row_end && ({1'b0, row_r} >= (rows_c - CFG_W'(1)));
    slot_mid  = slot_r + POS_W'(first_col);
    end_pos   = nz_r + POS_W'(nonzero);
  end

  always_comb begin
    bundle.mask.has_start   = first_col;
    bundle.mask.has_payload = nonzero;
    bundle.mask.has_end     = blk_end;
    bundle.value_bits       = elem_bits;
    bundle.block_offset     = off_r;
    bundle.start_pos        = nz_r;
    bundle.start_slot       = slot_r;
    bundle.end_pos          = end_pos;
    bundle.end_slot         = slot_mid;
    bundle.end_of_matrix    = mat_end;
  end

  always_comb begin
    nz_nxt   = end_pos;
    slot_nxt = slot_mid + POS_W'(blk_end);
    row_nxt  = row_r;
    priority if (mat_end) begin
      col_nxt  = '0;
      off_nxt  = '0;
      row_nxt  = '0;
      nz_nxt   = '0;
      slot_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      off_nxt = '0;
      row_nxt = row_r + CNT_W'(1);
    end else begin
      col_nxt = col_r + CNT_W'(1);
      off_nxt = blk_end ? '0 : off_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      off_r  <= '0;
      row_r  <= '0;
      nz_r   <= '0;
      slot_r <= '0;
    end else if (elem_beat) begin
      col_r  <= col_nxt;
      off_r  <= off_nxt;
      row_r  <= row_nxt;
      nz_r   <= nz_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

/* design/brse_serializer.sv */
// Result register: holds one element's bundle and emits its results one beat at a time.
module brse_serializer
  import brse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  bundle_t     bundle_in,
  output logic        can_load,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        res_kind,
  output logic [95:0] res_data,
  output logic        res_last
);

  bundle_t          bund_r;
  logic [2:0]       pend_r, pend_nxt, pend_rem;
  logic             take;
  logic [ELEM_W-1:0] value_bits;
  logic [CNT_W-1:0] block_offset;
  logic [POS_W-1:0] position, pointer_slot;
  logic             eom;

  assign res_valid = pend_r != '0;
  assign take      = res_valid && res_ready;
  assign pend_rem  = pend_r & (pend_r - 3'd1);
  assign can_load  = (pend_r == '0) || (take && pend_rem == '0);

  always_comb begin
    res_kind     = KIND_POINTER;
    value_bits   = '0;
    block_offset = '0;
    priority if (pend_r[0]) begin
      position     = bund_r.start_pos;
      pointer_slot = bund_r.start_slot;
      eom          = 1'b0;
    end else if (pend_r[1]) begin
      res_kind     = KIND_PAYLOAD;
      value_bits   = bund_r.value_bits;
      block_offset = bund_r.block_offset;
      position     = bund_r.start_pos;
      pointer_slot = '0;
      eom          = 1'b0;
    end else begin
      // block-end pointer
      position     = bund_r.end_pos;
      pointer_slot = bund_r.end_slot;
      eom          = bund_r.end_of_matrix;
    end
    res_last = pend_rem == '0;
    res_data = {1'b0, eom, pointer_slot, position, block_offset, value_bits};
  end

  always_comb begin
    priority if (load) pend_nxt = bundle_in.mask;
    else if (take)     pend_nxt = pend_rem;
    else               pend_nxt = pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bund_r <= bundle_in;
    end
  end

endmodule

/* bench/tb.sv */
// Self-checking bench for the blocked sparse row encoder: dense elements in, CSR beats checked.
module tb;
  import brse_pkg::*;

  localparam int ITEM_TARGET    = 410;
  localparam int IDLE_SETTLE    = 4;    // an element with no beats may still be in flight
  localparam int TAIL_CYCLES    = 8;    // room for stray beats after the last expected one
  localparam int WATCHDOG_LIMIT = 1000; // legal quiet stretches stay far shorter than this
  localparam int MAX_REPORTS    = 10;

  // One result beat as the bench predicts and observes it
  typedef struct packed {
    logic              kind;
    logic [ELEM_W-1:0] value_bits;
    logic [CNT_W-1:0]  block_offset;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  pointer_slot;
    logic              end_of_matrix;
    logic              last_beat;
  } csr_beat_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [12:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] element_bits
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;         // [31:0] value, [43:32] offset, [68:44] position,
                                  // [93:69] slot, [94] end_of_matrix
  logic        out_tuser;         // [0] kind
  logic        out_tlast;

  blocked_sparse_row_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the encoder: registers as written, counters as after reset
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] rows_reg = CFG_W'(4096);
  logic [CFG_W-1:0] cols_reg = CFG_W'(4096);
  logic [CFG_W-1:0] bw_reg   = CFG_W'(64);
  logic [CNT_W-1:0] col_idx  = '0;
  logic [CNT_W-1:0] blk_off  = '0;
  logic [CNT_W-1:0] row_idx  = '0;
  logic [POS_W-1:0] nz_total = '0;   // doubles as next payload index
  logic [POS_W-1:0] slot_idx = '0;   // next row-block pointer slot

  csr_beat_t pending_beats[$];       // predicted beats, oldest first
  int        elements_sent = 0;
  int        fail_count    = 0;
  int        report_count  = 0;
  bit        steady_flow   = 1'b0;   // when set neither side idles

  // Zero and oversized register values saturate into the legal range
  function automatic int effective_limit(logic [CFG_W-1:0] v, int hi);
    if (v == '0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Predict the beats of one accepted element and advance the shadow counters
  function automatic void encode_element(logic [ELEM_W-1:0] bits);
    int        rows;
    int        cols;
    int        bw;
    int        n;
    logic      nonzero;
    logic      row_end;
    logic      blk_end;
    logic      mat_end;
    csr_beat_t beats[3];
    rows    = effective_limit(rows_reg, MAX_ROWS);
    cols    = effective_limit(cols_reg, MAX_COLS);
    bw      = effective_limit(bw_reg, MAX_COLS);
    nonzero = (bits[30:0] != '0);    // either signed zero is zero, NaN is not
    // "at or beyond" so a shrunk limit ends the row, block or matrix at once
    row_end = int'(col_idx) >= cols - 1;
    blk_end = row_end || int'(blk_off) >= bw - 1;
    mat_end = row_end && int'(row_idx) >= rows - 1;
    n = 0;
    if (col_idx == '0) begin
      beats[n]              = '0;
      beats[n].kind         = KIND_POINTER;
      beats[n].position     = nz_total;
      beats[n].pointer_slot = slot_idx;
      slot_idx              = slot_idx + 1'b1;
      n++;
    end
    if (nonzero) begin
      beats[n]              = '0;
      beats[n].kind         = KIND_PAYLOAD;
      beats[n].value_bits   = bits;
      beats[n].block_offset = blk_off;
      beats[n].position     = nz_total;
      nz_total              = nz_total + 1'b1;
      n++;
    end
    if (blk_end) begin
      beats[n]               = '0;
      beats[n].kind          = KIND_POINTER;
      beats[n].position      = nz_total;
      beats[n].pointer_slot  = slot_idx;
      beats[n].end_of_matrix = mat_end;
      slot_idx               = slot_idx + 1'b1;
      n++;
    end
    if (n > 0) beats[n-1].last_beat = 1'b1;
    for (int i = 0; i < n; i++) pending_beats.push_back(beats[i]);

    if (mat_end) begin
      col_idx  = '0;
      blk_off  = '0;
      row_idx  = '0;
      nz_total = '0;
      slot_idx = '0;
    end else if (row_end) begin
      col_idx = '0;
      blk_off = '0;
      row_idx = row_idx + 1'b1;
    end else begin
      col_idx = col_idx + 1'b1;
      blk_off = blk_end ? '0 : blk_off + 1'b1;
    end
  endfunction

  function automatic string beat_text(csr_beat_t b);
    return $sformatf("kind=%0d value=%h offset=%0d position=%0d slot=%0d eom=%0d last=%0d",
                     b.kind, b.value_bits, b.block_offset, b.position, b.pointer_slot,
                     b.end_of_matrix, b.last_beat);
  endfunction

  // Mix of zeros of both signs, NaN/infinity, subnormals and plain random bits
  function automatic logic [ELEM_W-1:0] random_element();
    logic [ELEM_W-1:0] bits;
    bits = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2: bits = '0;
      3:       bits = 32'h8000_0000;
      4:       bits[30:23] = 8'hFF;
      5:       bits[30:23] = 8'h00;
      default: ;
    endcase
    return bits;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // valid stays high across back-to-back beats; it drops only for a drawn gap or a drain
  task automatic send_element(input logic [ELEM_W-1:0] bits);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bits;
    do @(posedge clk); while (!in_tready);
    encode_element(bits);
    elements_sent++;
  endtask

  // Hold off the element stream until every predicted beat has been seen
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROWS_IN_USE: rows_reg = value;
      REG_COLS_IN_USE: cols_reg = value;
      REG_BLOCK_WIDTH: bw_reg   = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int rows, input int cols, input int bw);
    write_register(REG_ROWS_IN_USE, CFG_W'(rows));
    write_register(REG_COLS_IN_USE, CFG_W'(cols));
    write_register(REG_BLOCK_WIDTH, CFG_W'(bw));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, one draw per accepted beat
  // ---------------------------------------------------------------------------
  int ready_hold = 0;

  always @(posedge clk) begin : drive_ready
    int stall;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1) out_tready <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      stall = steady_flow ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        ready_hold <= stall;
      end
    end else if (!out_tready) begin
      out_tready <= 1'b1;
    end
  end

  // Each accepted beat is matched against the oldest prediction
  always @(posedge clk) begin : check_beats
    csr_beat_t got;
    csr_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind          = out_tuser;
      got.value_bits    = out_tdata[31:0];
      got.block_offset  = out_tdata[43:32];
      got.position      = out_tdata[68:44];
      got.pointer_slot  = out_tdata[93:69];
      got.end_of_matrix = out_tdata[94];
      got.last_beat     = out_tlast;
      if (pending_beats.size() == 0) begin
        fail_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("unexpected beat: %s", beat_text(got));
        end
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("beat mismatch\n  expected %s\n  actual   %s",
                     beat_text(want), beat_text(got));
          end
        end
      end
    end
  end

  // Watchdog: a long stretch with no beat moved on any channel means a hang
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // 2x5 matrix, width-2 blocks with a partial last block; zero at row start,
  // zero inside a block (no beats), zero closing a block, NaN, inf, subnormals
  task automatic test_directed_shapes();
    apply_setting(2, 5, 2);
    send_element(32'h0000_0000);
    send_element(32'h8000_0001);
    send_element(32'h7FFF_FFFF);
    send_element(32'h7FC0_0001);
    send_element(32'h0000_0001);
    send_element(32'h7F80_0000);
    send_element(32'h3F80_0000);
    send_element(32'h0000_0000);
    send_element(32'h8000_0000);
    send_element(32'hFFFF_FFFF);
  endtask

  // Zero registers act as one: every element is a full matrix with up to three beats.
  // Oversized values saturate, leaving the matrix open after one row.
  task automatic test_register_extremes();
    apply_setting(0, 0, 0);
    send_element(32'hFFFF_FFFF);
    send_element(32'h0000_0000);
    send_element(32'h8000_0000);
    send_element(32'h7FC0_0000);
    apply_setting(8191, 3, 8191);
    send_element(32'h0000_0000);
    send_element(32'hAAAA_AAAA);
    send_element(32'h5555_5555);
  endtask

  // Shrinking the row length below the current column ends row and matrix at once
  task automatic test_change_mid_matrix();
    apply_setting(2, 6, 4);
    repeat (4) send_element(random_element());
    write_register(REG_COLS_IN_USE, CFG_W'(2));
    send_element(32'h4049_0FDB);
    send_element(32'h0000_0000);
    send_element(32'hC000_0000);
  endtask

  // Sender stops mid-matrix until the result side has caught up completely
  task automatic test_drain_pause();
    apply_setting(3, 7, 3);
    repeat (10) send_element(random_element());
    wait_for_drain();
    repeat (11) send_element(random_element());
  endtask

  // Mostly whole matrices with random content, some partial runs that leave
  // counters mid-row for the next setting, some with no idling at all
  task automatic test_random_matrices();
    int rows;
    int cols;
    int bw;
    int count;
    int pick;
    while (elements_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      rows = $urandom_range(1, 4);
      cols = $urandom_range(1, 10);
      bw   = $urandom_range(1, cols + 1);
      if (pick == 0) begin
        bw = 0;
      end else if (pick == 1) begin
        bw = 8191;
      end else if (pick == 2) begin
        rows = 4096;
        cols = 4096;
        bw   = $urandom_range(1, 16);
      end
      apply_setting(rows, cols, bw);
      steady_flow = ($urandom_range(0, 3) == 0);
      if (pick == 2 || $urandom_range(0, 4) == 0)
        count = $urandom_range(1, 25);
      else
        count = rows * cols * $urandom_range(1, 2);
      repeat (count) begin
        send_element(random_element());
        if ($urandom_range(0, 63) == 0) wait_for_drain();
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_shapes();
    test_register_extremes();
    test_change_mid_matrix();
    test_drain_pause();
    test_random_matrices();

    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    fail_count += pending_beats.size();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/brse_pkg.sv
design/brse_core.sv
design/brse_serializer.sv
design/blocked_sparse_row_encoder.sv
bench/tb.sv
